>>> hdl/imuffu_pkg.sv
// Shared types and constants for the IMU FIFO frame unpacker.
`timescale 1ns / 1ps
package imuffu_pkg;

   localparam int FRAME_LEN = 7;
   localparam int AXES = 6;
   localparam int WORD_W = 16;
   localparam int TICK_W = 64;
   localparam int TIME_W = 32;
   localparam int POS_W = $clog2(FRAME_LEN);

   localparam logic [WORD_W-1:0] SKIP_MARK_A = 16'h7F01;
   localparam logic [WORD_W-1:0] SKIP_MARK_B = 16'h7F02;
   localparam logic [WORD_W-1:0] US_PER_TICK_RESET = 16'd10000;

   // item kinds on req_tuser
   localparam logic CMD_DATA = 1'b0;
   localparam logic CMD_FLUSH = 1'b1;

   // register word index
   localparam logic REG_US_PER_TICK = 1'b0;

   localparam int QUEUE_DEPTH_DEF = 2;

   typedef logic [AXES-1:0][WORD_W-1:0] axes_type;

   // one kept frame, handed from front to back
   typedef struct packed {
      logic [TICK_W-1:0] ticks;
      axes_type axes;
   } frame_rec_type;

endpackage

>>> hdl/imuffu_front.sv
// Front end: frame assembly, skip marks, tick extension and duplicate filter.
`timescale 1ns / 1ps
module imuffu_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,
   input  logic [15:0]           req_tdata,
   input  logic                  q_full,
   output logic                  push_valid,
   output imuffu_pkg::frame_rec_type push_data
);
   import imuffu_pkg::*;

   logic [POS_W-1:0]  pos_ff, pos_in, pos_cur;
   logic              seeded_ff, seeded_in;
   logic [TICK_W-1:0] ticks_ff, ticks_in, ticks_upd;
   axes_type          words_ff, words_in;
   axes_type          last_ff, last_in;
   logic [WORD_W-1:0] delta;
   logic              accept, is_last, skip, dup;

   // only the time stamp word needs queue room
   assign pos_cur = (pos_ff >= POS_W'(FRAME_LEN)) ? '0 : pos_ff;
   assign is_last = (pos_cur == POS_W'(FRAME_LEN - 1));
   assign req_tready = !q_full || !is_last;
   assign accept = req_tvalid && req_tready;

   assign skip = (words_ff[0] == SKIP_MARK_A) || (words_ff[3] == SKIP_MARK_B);
   assign delta = req_tdata - ticks_ff[WORD_W-1:0];
   assign ticks_upd = seeded_ff ? (ticks_ff + {{(TICK_W-WORD_W){1'b0}}, delta})
                                : {{(TICK_W-WORD_W){1'b0}}, req_tdata};
   assign dup = (words_ff == last_ff);

   always_comb begin
      pos_in = pos_ff;
      seeded_in = seeded_ff;
      ticks_in = ticks_ff;
      words_in = words_ff;
      last_in = last_ff;
      push_valid = 1'b0;
      if (accept) begin
         if (req_tuser == CMD_FLUSH) begin
            pos_in = '0;
            seeded_in = 1'b0;
            ticks_in = '0;
         end else if (!is_last) begin
            words_in[pos_cur] = req_tdata;
            pos_in = pos_cur + POS_W'(1);
         end else begin
            pos_in = '0;
            if (!skip) begin
               ticks_in = ticks_upd;
               seeded_in = 1'b1;
               if (!dup) begin
                  last_in = words_ff;
                  push_valid = 1'b1;
               end
            end
         end
      end
   end

   assign push_data.ticks = ticks_upd;
   assign push_data.axes = words_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         seeded_ff <= 1'b0;
         ticks_ff <= '0;
         last_ff <= '0;
      end else begin
         pos_ff <= pos_in;
         seeded_ff <= seeded_in;
         ticks_ff <= ticks_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

endmodule

>>> hdl/imuffu_queue.sv
// Short frame queue between front and back.
`timescale 1ns / 1ps
module imuffu_queue #(
   parameter int DEPTH = imuffu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push_valid,
   input  imuffu_pkg::frame_rec_type push_data,
   output logic                      full,
   output logic                      head_valid,
   output imuffu_pkg::frame_rec_type head_data,
   input  logic                      pop
);
   import imuffu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   frame_rec_type     mem [DEPTH];
   logic [PTR_W-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_push, do_pop;

   assign full = (cnt_ff == CNT_W'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data = mem[rd_ff];
   assign do_push = push_valid && !full;
   assign do_pop = pop && head_valid;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/imuffu_back.sv
// Back end: time scaling and the result output register.
`timescale 1ns / 1ps
module imuffu_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      head_valid,
   input  imuffu_pkg::frame_rec_type head_data,
   output logic                      pop,
   input  logic [15:0]               us_per_tick,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [191:0]              rsp_tdata
);
   import imuffu_pkg::*;

   logic                 valid_ff, valid_in;
   logic [TICK_W-1:0]    ticks_ff;
   axes_type             axes_ff;
   logic [TIME_W-1:0]    time_ff, time_calc;
   logic [47:0]          prod_lo;
   logic [15:0]          prod_hi;

   function automatic logic [47:0] ticks_lo_ext(input logic [TICK_W-1:0] t);
      ticks_lo_ext = {16'b0, t[31:0]};
   endfunction

   // floor(t * u / 256) mod 2^32: only t[39:0] reaches the low 32 bits
   assign prod_lo = ticks_lo_ext(head_data.ticks) * {32'b0, us_per_tick};
   assign prod_hi = {8'b0, head_data.ticks[39:32]} * {8'b0, us_per_tick[7:0]};
   assign time_calc = prod_lo[39:8] + {prod_hi[7:0], 24'b0};

   assign pop = head_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ticks_ff <= head_data.ticks;
         axes_ff <= head_data.axes;
         time_ff <= time_calc;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = {time_ff, ticks_ff, axes_ff};

endmodule

>>> hdl/imu_fifo_frame_unpacker_top.sv
// Top level of the IMU FIFO frame unpacker.
`timescale 1ns / 1ps
// Takes one 16-bit sensor FIFO word per item on req_ (req_tuser = 1 flushes:
// frame position, seeding and tick count go back to zero; a partial frame
// is lost). Every seven data words form a frame: accel X/Y/Z, gyro X/Y/Z,
// time stamp. A frame whose first word is 0x7F01 or whose fourth word is
// 0x7F02 is dropped untouched. Otherwise the 16-bit stamp is unwrapped into
// a 64-bit tick count (the first frame after reset or flush seeds it), and
// the frame is dropped if its six axes match the last frame sent out (this
// memory survives flush and resets to all zero). Kept frames leave on rsp_
// with tick count and time_us = low 32 bits of floor(ticks * us_per_tick/256).
// Rate: one word per cycle, but for stalls on a full queue. The front end
// decides everything on the stamp word and pushes a frame into a two-entry
// queue; the back end scales time with a 32x16 multiply and loads the output
// register, which drives rsp_tvalid; a kept frame waits in the queue for it.
// req_tready falls only on a stamp word while the queue is full.
// Register map (APB, 32-bit): 0x0 us_per_tick[15:0], Q8.8, reset 10000.
module imu_fifo_frame_unpacker_top #(
   parameter int QUEUE_DEPTH = imuffu_pkg::QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // input items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [15:0]  req_tdata,   // [15:0] data_word
   input  logic         req_tuser,   // [0] cmd: 0 data, 1 flush
   // result items
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [191:0] rsp_tdata,   // accel_x, accel_y, accel_z, gyro_x,
                                     // gyro_y, gyro_z (16 each), tick_count
                                     // (64), time_us (32), low bits first
   // configuration
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [2:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   import imuffu_pkg::*;

   logic [WORD_W-1:0] us_per_tick_ff, us_per_tick_in;
   logic              csr_wr;
   logic              q_full, q_push, q_head_valid, q_pop;
   frame_rec_type     q_push_data, q_head_data;

   // config register: word index is paddr[2]
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      us_per_tick_in = us_per_tick_ff;
      if (csr_wr && (csr_paddr[2] == REG_US_PER_TICK)) begin
         us_per_tick_in = csr_pwdata[WORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         us_per_tick_ff <= US_PER_TICK_RESET;
      end else begin
         us_per_tick_ff <= us_per_tick_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_US_PER_TICK)
                       ? {16'b0, us_per_tick_ff} : 32'b0;

   imuffu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .q_full     (q_full),
      .push_valid (q_push),
      .push_data  (q_push_data)
   );

   imuffu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push),
      .push_data  (q_push_data),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_data  (q_head_data),
      .pop        (q_pop)
   );

   imuffu_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_valid  (q_head_valid),
      .head_data   (q_head_data),
      .pop         (q_pop),
      .us_per_tick (us_per_tick_ff),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

endmodule

>>> hdl/imuffu_checker.sv
// Port-level checks for the IMU FIFO frame unpacker, bound to the top level.
`timescale 1ns / 1ps
module imuffu_checker (
   input logic         clock,
   input logic         reset,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [191:0] rsp_tdata,
   input logic         csr_psel,
   input logic         csr_penable,
   input logic         csr_pwrite,
   input logic [2:0]   csr_paddr,
   input logic [31:0]  csr_pwdata,
   input logic [31:0]  csr_prdata
);
   logic [95:0] last_axes_ff;

   // axes of the last item sent; zero after reset like the block's own copy
   always_ff @(posedge clock) begin
      if (reset) begin
         last_axes_ff <= '0;
      end else if (rsp_tvalid && rsp_tready) begin
         last_axes_ff <= rsp_tdata[95:0];
      end
   end

   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed or vanished");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready |-> rsp_tdata[95:0] != last_axes_ff)
      else $error("repeated sample was sent");

   assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && !csr_paddr[2]
      |=> csr_paddr[2] || csr_prdata[15:0] == $past(csr_pwdata[15:0]))
      else $error("us_per_tick read back differs from write");

endmodule

bind imu_fifo_frame_unpacker_top imuffu_checker u_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_tvalid  (rsp_tvalid),
   .rsp_tready  (rsp_tready),
   .rsp_tdata   (rsp_tdata),
   .csr_psel    (csr_psel),
   .csr_penable (csr_penable),
   .csr_pwrite  (csr_pwrite),
   .csr_paddr   (csr_paddr),
   .csr_pwdata  (csr_pwdata),
   .csr_prdata  (csr_prdata)
);
